// ===== rtl/luma_brightness_adjust_unit_macros.svh =====
// Assertion helpers for the checker file.
`ifndef LUMA_BRIGHTNESS_ADJUST_UNIT_MACROS_SVH
`define LUMA_BRIGHTNESS_ADJUST_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define LBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lba_pkg.sv =====
package lba_pkg;

    // Fixed-point accumulator: channel sums in units of 1/65536
    localparam int AccW = 27;
    typedef logic signed [AccW-1:0] acc_t;

    localparam int FracW     = 16;
    localparam int PipeDepth = 5;
    localparam int DepthW    = $clog2(PipeDepth + 1);

    localparam acc_t OneHalf       = acc_t'(32768);
    localparam acc_t ChromaBiasFix = acc_t'(128 * 65536);
    localparam logic [8:0] ChromaBias = 9'd128;

    // Forward coefficients (x65536)
    localparam acc_t CoefYR  = acc_t'(19595);
    localparam acc_t CoefYG  = acc_t'(38470);
    localparam acc_t CoefYB  = acc_t'(7471);
    localparam acc_t CoefCbR = acc_t'(-11058);
    localparam acc_t CoefCbG = acc_t'(-21710);
    localparam acc_t CoefCbB = acc_t'(32768);
    localparam acc_t CoefCrR = acc_t'(32768);
    localparam acc_t CoefCrG = acc_t'(-27439);
    localparam acc_t CoefCrB = acc_t'(-5329);

    // Inverse coefficients (x65536), applied to chroma minus 128
    localparam acc_t CoefRCr = acc_t'(91881);
    localparam acc_t CoefGCb = acc_t'(-22553);
    localparam acc_t CoefGCr = acc_t'(-46802);
    localparam acc_t CoefBCb = acc_t'(116130);

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    typedef struct packed {
        logic [7:0] alpha;
        acc_t       yr;
        acc_t       yg;
        acc_t       yb;
        acc_t       cbr;
        acc_t       cbg;
        acc_t       cbb;
        acc_t       crr;
        acc_t       crg;
        acc_t       crb;
    } fwd_prod_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] y;
        logic [7:0] cb;
        logic [7:0] cr;
    } ycc_t;

    typedef struct packed {
        logic [7:0] alpha;
        acc_t       yfix;
        acc_t       rcr;
        acc_t       gcb;
        acc_t       gcr;
        acc_t       bcb;
    } inv_prod_t;

    function automatic acc_t mul_u8(logic [7:0] v, acc_t c);
        acc_t x;
        x = acc_t'($signed({1'b0, v}));
        return x * c;
    endfunction

    function automatic acc_t mul_s9(logic signed [8:0] v, acc_t c);
        acc_t x;
        x = acc_t'(v);
        return x * c;
    endfunction

    // Half-up rounding of a 1/65536 sum to a byte, clamped to 0..255
    function automatic logic [7:0] round_clamp(acc_t s);
        acc_t v;
        v = s + OneHalf;
        if (v[AccW-1])
            return 8'd0;
        else if (v[AccW-2:FracW] > (AccW-1-FracW)'(255))
            return 8'hFF;
        else
            return v[FracW+7:FracW];
    endfunction

endpackage

// ===== rtl/lba_in_if.sv =====
interface lba_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] alpha_in;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, output alpha_in, output red_in, output green_in,
                    output blue_in, input ready);
    modport sink   (input valid, input alpha_in, input red_in, input green_in,
                    input blue_in, output ready);
endinterface

// ===== rtl/lba_out_if.sv =====
interface lba_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] alpha_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    modport source (output valid, output alpha_out, output red_out, output green_out,
                    output blue_out, input ready);
    modport sink   (input valid, input alpha_out, input red_out, input green_out,
                    input blue_out, output ready);
endinterface

// ===== rtl/lba_cfg_if.sv =====
interface lba_cfg_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] brightness_offset;

    modport source (output valid, output brightness_offset, input ready);
    modport sink   (input valid, input brightness_offset, output ready);
endinterface

// ===== rtl/lba_rgb2ycc.sv =====
module lba_rgb2ycc
    import lba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  pix_t      in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output ycc_t      out_data
);

    logic      s1_valid_reg;
    fwd_prod_t s1_data_reg;
    fwd_prod_t s1_data_next;
    logic      s2_valid_reg;
    ycc_t      s2_data_reg;
    ycc_t      s2_data_next;
    logic      s1_ready;
    logic      s2_ready;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // stage 1: constant products
    always_comb
    begin
        s1_data_next.alpha = in_data.alpha;
        s1_data_next.yr    = mul_u8(in_data.red,   CoefYR);
        s1_data_next.yg    = mul_u8(in_data.green, CoefYG);
        s1_data_next.yb    = mul_u8(in_data.blue,  CoefYB);
        s1_data_next.cbr   = mul_u8(in_data.red,   CoefCbR);
        s1_data_next.cbg   = mul_u8(in_data.green, CoefCbG);
        s1_data_next.cbb   = mul_u8(in_data.blue,  CoefCbB);
        s1_data_next.crr   = mul_u8(in_data.red,   CoefCrR);
        s1_data_next.crg   = mul_u8(in_data.green, CoefCrG);
        s1_data_next.crb   = mul_u8(in_data.blue,  CoefCrB);
    end

    // stage 2: sum, round, clamp
    always_comb
    begin
        s2_data_next.alpha = s1_data_reg.alpha;
        s2_data_next.y     = round_clamp(s1_data_reg.yr + s1_data_reg.yg + s1_data_reg.yb);
        s2_data_next.cb    = round_clamp(s1_data_reg.cbr + s1_data_reg.cbg
                                         + s1_data_reg.cbb + ChromaBiasFix);
        s2_data_next.cr    = round_clamp(s1_data_reg.crr + s1_data_reg.crg
                                         + s1_data_reg.crb + ChromaBiasFix);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
            s1_data_reg <= s1_data_next;
        if (s2_ready && s1_valid_reg)
            s2_data_reg <= s2_data_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

// ===== rtl/lba_luma_offset.sv =====
module lba_luma_offset
    import lba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic signed [8:0] brightness_offset,
    input  logic              in_valid,
    output logic              in_ready,
    input  ycc_t              in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ycc_t              out_data
);

    logic              s3_valid_reg;
    ycc_t              s3_data_reg;
    ycc_t              s3_data_next;
    logic signed [9:0] y_sum;

    assign in_ready = !s3_valid_reg || out_ready;

    always_comb
    begin
        y_sum = $signed({2'b00, in_data.y}) + 10'(brightness_offset);
        s3_data_next = in_data;
        if (y_sum < 0)
            s3_data_next.y = 8'd0;
        else if (y_sum > 10'sd255)
            s3_data_next.y = 8'hFF;
        else
            s3_data_next.y = y_sum[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (in_ready)
            s3_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s3_data_reg <= s3_data_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

endmodule

// ===== rtl/lba_ycc2rgb.sv =====
module lba_ycc2rgb
    import lba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ycc_t      in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output pix_t      out_data
);

    logic              s4_valid_reg;
    inv_prod_t         s4_data_reg;
    inv_prod_t         s4_data_next;
    logic              s5_valid_reg;
    pix_t              s5_data_reg;
    pix_t              s5_data_next;
    logic              s4_ready;
    logic              s5_ready;
    logic signed [8:0] dcb;
    logic signed [8:0] dcr;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign in_ready = s4_ready;

    // stage 4: centered chroma times inverse coefficients
    always_comb
    begin
        dcb = $signed({1'b0, in_data.cb} - ChromaBias);
        dcr = $signed({1'b0, in_data.cr} - ChromaBias);
        s4_data_next.alpha = in_data.alpha;
        s4_data_next.yfix  = acc_t'({in_data.y, 16'h0000});
        s4_data_next.rcr   = mul_s9(dcr, CoefRCr);
        s4_data_next.gcb   = mul_s9(dcb, CoefGCb);
        s4_data_next.gcr   = mul_s9(dcr, CoefGCr);
        s4_data_next.bcb   = mul_s9(dcb, CoefBCb);
    end

    // stage 5: sum, round, clamp into the output register
    always_comb
    begin
        s5_data_next.alpha = s4_data_reg.alpha;
        s5_data_next.red   = round_clamp(s4_data_reg.yfix + s4_data_reg.rcr);
        s5_data_next.green = round_clamp(s4_data_reg.yfix + s4_data_reg.gcb
                                         + s4_data_reg.gcr);
        s5_data_next.blue  = round_clamp(s4_data_reg.yfix + s4_data_reg.bcb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s4_ready)
                s4_valid_reg <= in_valid;
            if (s5_ready)
                s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && in_valid)
            s4_data_reg <= s4_data_next;
        if (s5_ready && s4_valid_reg)
            s5_data_reg <= s5_data_next;
    end

    assign out_valid = s5_valid_reg;
    assign out_data  = s5_data_reg;

endmodule

// ===== rtl/luma_brightness_adjust_unit.sv =====
// Luma brightness adjust: each ARGB pixel is converted to full-range BT.601
// YCbCr (16-bit fractional coefficients, half-up rounding, bytes clamped to
// 0..255), the signed brightness offset is added to Y with clamping, and the
// pixel is converted back to RGB with the same rounding and clamping. Alpha
// passes through untouched. Throughput is one pixel per clock while the
// result is not stalled, with no dependence between pixels; the result is
// registered through the five register stages (forward products, forward
// sums, luma offset, inverse products, inverse sums into the output
// register). Backpressure on the result stalls the pipe stage by stage, so
// bubbles are squeezed out and no pixel is lost or repeated.
// The offset register (reset 0) is written through the cfg channel, which is
// always ready; write it only while no pixel is in flight.
module luma_brightness_adjust_unit
    import lba_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    lba_in_if.sink   pixel,
    lba_out_if.source result,
    lba_cfg_if.sink  cfg
);

    // brightness offset register
    logic signed [8:0] offset_reg;

    // inter-stage handshakes
    logic in_ready;
    pix_t in_pix;
    logic fwd_valid;
    logic fwd_ready;
    ycc_t fwd_data;
    logic lum_valid;
    logic lum_ready;
    ycc_t lum_data;
    logic out_valid;
    pix_t out_pix;

    // cfg writes are registered into the offset register; channel never stalls
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else if (cfg.valid)
            offset_reg <= cfg.brightness_offset;
    end

    assign in_pix.alpha = pixel.alpha_in;
    assign in_pix.red   = pixel.red_in;
    assign in_pix.green = pixel.green_in;
    assign in_pix.blue  = pixel.blue_in;
    assign pixel.ready  = in_ready;

    // stages 1-2: RGB to YCbCr
    lba_rgb2ycc u_rgb2ycc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (in_ready),
        .in_data   (in_pix),
        .out_valid (fwd_valid),
        .out_ready (fwd_ready),
        .out_data  (fwd_data)
    );

    // stage 3: add offset to Y
    lba_luma_offset u_luma_offset (
        .clk               (clk),
        .rst_n             (rst_n),
        .brightness_offset (offset_reg),
        .in_valid          (fwd_valid),
        .in_ready          (fwd_ready),
        .in_data           (fwd_data),
        .out_valid         (lum_valid),
        .out_ready         (lum_ready),
        .out_data          (lum_data)
    );

    // stages 4-5: YCbCr back to RGB, last stage is the output register
    lba_ycc2rgb u_ycc2rgb (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lum_valid),
        .in_ready  (lum_ready),
        .in_data   (lum_data),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .out_data  (out_pix)
    );

    assign result.valid     = out_valid;
    assign result.alpha_out = out_pix.alpha;
    assign result.red_out   = out_pix.red;
    assign result.green_out = out_pix.green;
    assign result.blue_out  = out_pix.blue;

endmodule

// ===== rtl/lba_checker.sv =====
`include "luma_brightness_adjust_unit_macros.svh"

module lba_checker
    import lba_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        pixel_valid,
    input logic        pixel_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [31:0] result_word,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // pixels accepted but not yet delivered
    logic [DepthW-1:0] outstanding_reg;
    logic [DepthW-1:0] outstanding_next;
    logic              pix_xfer;
    logic              res_xfer;

    assign pix_xfer = pixel_valid && pixel_ready;
    assign res_xfer = result_valid && result_ready;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (pix_xfer && !res_xfer)
            outstanding_next = outstanding_reg + DepthW'(1);
        else if (res_xfer && !pix_xfer)
            outstanding_next = outstanding_reg - DepthW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= '0;
        else
            outstanding_reg <= outstanding_next;
    end

    `LBA_ASSERT_IMPLY(a_no_phantom, clk, rst_n, result_valid, outstanding_reg != '0, "result without accepted pixel")
    `LBA_ASSERT_IMPLY(a_depth, clk, rst_n, 1'b1, outstanding_reg <= DepthW'(PipeDepth), "more pixels in flight than stages")
    `LBA_ASSERT_IMPLY(a_drained_ready, clk, rst_n, !result_valid, pixel_ready, "input stalled with empty output")
    `LBA_ASSERT_IMPLY(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready, "cfg write stalled")
    `LBA_ASSERT_NEXT(a_out_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_word), "stalled result changed")

endmodule

bind luma_brightness_adjust_unit lba_checker u_lba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel.valid),
    .pixel_ready  (pixel.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_word  ({result.alpha_out, result.red_out, result.green_out, result.blue_out}),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready)
);
